@@ design/tdp_pkg.sv @@
`timescale 1ns / 1ps

package tdp_pkg;

  // default operand width
  localparam int DATA_WIDTH = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV3,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_FIN
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/tdp_divider.sv @@
`timescale 1ns / 1ps

module tdp_divider #(
  parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output tdp_pkg::div_stat_t    stat,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  localparam int CntW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [CntW-1:0]       cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DATA_WIDTH-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    quo_nxt = {quo_r[DATA_WIDTH-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DATA_WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // checks
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == '0) |=> done_r)
    else $error("divider missed done after last step");

endmodule

@@ design/trial_division_primality_test.sv @@
`timescale 1ns / 1ps

// trial division primality test, 6k +/- 1 wheel
//
// input channel in_*: one beat carries a signed value to test in in_tdata.
// output channel out_*: one beat per input, out_tdata[0] = 1 when prime.
// negatives, 0, 1 and even values are decided without dividing, as are
// 2 and 3. otherwise a shared restoring divider (one quotient bit per
// cycle) computes value / d for d = 3, then 5, 7, 11, 13, ... while
// d <= value / d. trivial values go from the idle state straight to the
// finish state. the number of divisions is one for the test by 3 plus one
// per trial divisor, up to 2 * pairs + 2 for a prime, pairs being the
// 6k +/- 1 pairs with d <= value / d (about 7700 for 31-bit primes).
// one item is worked on at a time: in_tready is high only in the idle state.
// the result sits in an output register, so the next value is accepted
// while a result waits; a stalled receiver holds the sequencer at the end
// of the following item. reset (rst_n low, synchronous) empties the block.
module trial_division_primality_test #(
  parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata    // is_prime, zeros
);

  localparam logic [DATA_WIDTH-1:0] One   = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] Two   = DATA_WIDTH'(2);
  localparam logic [DATA_WIDTH-1:0] Three = DATA_WIDTH'(3);
  localparam logic [DATA_WIDTH-1:0] Five  = DATA_WIDTH'(5);
  localparam logic [DATA_WIDTH-1:0] Six   = DATA_WIDTH'(6);

  tdp_pkg::state_t       state_r, state_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] d_r, d_nxt;
  logic                  res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_bit_r, out_bit_nxt;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_divisor;
  logic [DATA_WIDTH-1:0] div_dividend;
  tdp_pkg::div_stat_t    div_stat;
  logic [DATA_WIDTH-1:0] div_q;
  logic [DATA_WIDTH-1:0] div_r;
  logic [DATA_WIDTH-1:0] v_in;
  logic                  in_beat;

  assign v_in    = in_tdata[DATA_WIDTH-1:0];
  assign in_beat = in_tvalid && in_tready;

  // shared divider
  tdp_divider #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q),
    .remainder(div_r)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    d_r       <= d_nxt;
    res_r     <= res_nxt;
    out_bit_r <= out_bit_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    in_tready     = 1'b0;
    div_start     = 1'b0;
    div_dividend  = val_r;
    div_divisor   = Three;
    unique case (state_r)
      tdp_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        div_dividend = v_in;
        if (in_beat) begin
          val_nxt = v_in;
          priority if (v_in[DATA_WIDTH-1] || v_in <= One) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_FIN;
          end else if (v_in == Two || v_in == Three) begin
            res_nxt   = 1'b1;
            state_nxt = tdp_pkg::ST_FIN;
          end else if (!v_in[0]) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = tdp_pkg::ST_DIV3;
          end
        end
      end
      tdp_pkg::ST_DIV3: begin
        div_divisor = Five;
        if (div_stat.done) begin
          if (div_r == '0) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_FIN;
          end else begin
            d_nxt     = Five;
            div_start = 1'b1;
            state_nxt = tdp_pkg::ST_DIV_LO;
          end
        end
      end
      tdp_pkg::ST_DIV_LO: begin
        div_divisor = d_r + Two;
        if (div_stat.done) begin
          priority if (d_r > div_q) begin
            res_nxt   = 1'b1;
            state_nxt = tdp_pkg::ST_FIN;
          end else if (div_r == '0) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_FIN;
          end else begin
            div_start = 1'b1;
            state_nxt = tdp_pkg::ST_DIV_HI;
          end
        end
      end
      tdp_pkg::ST_DIV_HI: begin
        div_divisor = d_r + Six;
        if (div_stat.done) begin
          if (div_r == '0) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::ST_FIN;
          end else begin
            d_nxt     = d_r + Six;
            div_start = 1'b1;
            state_nxt = tdp_pkg::ST_DIV_LO;
          end
        end
      end
      tdp_pkg::ST_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = res_r;
          state_nxt     = tdp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tdp_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};

  // checks
  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_DIV_LO || state_r == tdp_pkg::ST_DIV_HI) |-> d_r[0])
    else $error("trial divisor is even");
  a_wait_divider: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdp_pkg::ST_IDLE || state_r == tdp_pkg::ST_FIN) |-> !div_stat.busy)
    else $error("divider busy outside a division state");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result beat changed while stalled");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int DATA_WIDTH = tdp_pkg::DATA_WIDTH;
  localparam int IN_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;    // value
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [7:0]      out_tdata;        // is_prime, zeros

  // flags predicted for accepted values, oldest first
  logic prime_flags_q[$];
  int   mismatch_cnt = 0;
  bit   idle_en = 1'b1;

  trial_division_primality_test #(
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // primality by trial division over the 6k +/- 1 wheel
  function automatic logic prime_flag(logic [DATA_WIDTH-1:0] value);
    longint unsigned v;
    longint unsigned d;
    v = longint'(value) & ((64'd1 << DATA_WIDTH) - 1);
    if (value[DATA_WIDTH-1]) return 1'b0;
    if (v <= 1) return 1'b0;
    if (v <= 3) return 1'b1;
    if (v % 2 == 0 || v % 3 == 0) return 1'b0;
    for (d = 5; d <= v / d; d += 6) begin
      if (v % d == 0 || v % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // random value, biased toward cheap cases so the run stays short
  function automatic logic [DATA_WIDTH-1:0] random_value();
    int unsigned small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97};
    int unsigned p;
    int unsigned k;
    case ($urandom_range(0, 5))
      0: return DATA_WIDTH'($urandom() | MIN_NEG);
      1: return DATA_WIDTH'($urandom_range(0, 4095));
      2: return DATA_WIDTH'($urandom_range(0, 65535));
      3, 4: begin
        // 6k +/- 1 up to 60001: many primes, full divisor loops
        k = $urandom_range(1, 10000);
        return DATA_WIDTH'((6 * k) + ($urandom_range(0, 1) ? 1 : -1));
      end
      default: begin
        // wide value with a small factor, so any high bit can be set
        p = small_primes[$urandom_range(0, 11)];
        k = $urandom_range(1, int'(MAX_POS / p));
        return DATA_WIDTH'(p * k);
      end
    endcase
  endfunction

  // one input beat, with an optional idle burst in front
  task automatic send_value(logic [DATA_WIDTH-1:0] value);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(value);
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender until every predicted flag has come back
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (prime_flags_q.size() != 0) @(posedge clk);
  endtask

  // record accepted values and check result beats
  always @(posedge clk) begin
    logic want;
    if (rst_n && in_tvalid && in_tready) begin
      prime_flags_q.push_back(prime_flag(in_tdata[DATA_WIDTH-1:0]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (prime_flags_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: out_tdata=%h", out_tdata);
      end else begin
        want = prime_flags_q.pop_front();
        if (out_tdata !== {7'b0, want}) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("is_prime mismatch: expected %h actual %h", {7'b0, want}, out_tdata);
        end
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // edge values and every early exit
  task automatic test_special_values();
    logic [DATA_WIDTH-1:0] vals[$];
    vals = '{MIN_NEG, {DATA_WIDTH{1'b1}}, 0, 1, 2, 3, 4, 5, 6, 7, 9, 11, 13, 25, 35,
             49, 77, 121, 143, MAX_POS - 1, MAX_POS - 2, MAX_POS - 3, MAX_POS};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // random values under random idling on both sides
  task automatic test_random_values(int count);
    repeat (count) send_value(random_value());
  endtask

  // sender waits for a fully drained block, then restarts
  task automatic test_drained_restart();
    wait_results_done();
    repeat ($urandom_range(1, 17)) @(posedge clk);
    repeat (8) send_value(random_value());
  endtask

  // back-to-back beats with no idling at all
  task automatic test_full_rate();
    idle_en = 1'b0;
    repeat (20) send_value(random_value());
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_values();
    test_random_values(70);
    test_drained_restart();
    test_full_rate();

    wait_results_done();
    repeat (64) @(posedge clk);

    if (mismatch_cnt == 0 && prime_flags_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // time limit
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/tdp_pkg.sv
design/tdp_divider.sv
design/trial_division_primality_test.sv
tb/sv/tb_top.sv
